FILE: design/bsrg_pkg.sv
// shared types, codes and constants of the boot splash reset gesture sequencer
package bsrg_pkg;

    // widths
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned SLOT_W    = 8;
    localparam int unsigned CFG_NUM   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;

    // default number of test patterns
    localparam int unsigned PATTERN_COUNT_DEF = 4;

    // pattern slot before any pattern is drawn
    localparam logic [SLOT_W-1:0] SLOT_NONE = 8'hFF;

    // actions
    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_BOOT      = 2'd1;
    localparam logic [1:0] ACT_ON_DEMAND = 2'd2;
    localparam logic [1:0] ACT_TAKE      = 2'd3;

    // stages
    localparam logic [2:0] STAGE_IDLE     = 3'd0;
    localparam logic [2:0] STAGE_SELFTEST = 3'd1;
    localparam logic [2:0] STAGE_LOGO     = 3'd2;
    localparam logic [2:0] STAGE_RESET    = 3'd3;
    localparam logic [2:0] STAGE_STUCK    = 3'd4;
    localparam logic [2:0] STAGE_DONE     = 3'd5;

    // drawn screens
    localparam logic [2:0] REDRAW_NONE    = 3'd0;
    localparam logic [2:0] REDRAW_PATTERN = 3'd1;
    localparam logic [2:0] REDRAW_LOGO    = 3'd2;
    localparam logic [2:0] REDRAW_RESET   = 3'd3;
    localparam logic [2:0] REDRAW_STUCK   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELF_TEST_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOGO_TIME          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_DEADLINE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_MESSAGE_TIME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_MESSAGE_TIME = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ON_DEMAND_CEILING  = 3'd7;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SELF_TEST_TIME     = 16'd600;
    localparam logic [CFG_W-1:0] RST_PATTERN_PERIOD     = 16'd200;
    localparam logic [CFG_W-1:0] RST_LOGO_TIME          = 16'd600;
    localparam logic [CFG_W-1:0] RST_RESET_HOLD_TIME    = 16'd3000;
    localparam logic [CFG_W-1:0] RST_STUCK_DEADLINE     = 16'd10000;
    localparam logic [CFG_W-1:0] RST_RESET_MESSAGE_TIME = 16'd2000;
    localparam logic [CFG_W-1:0] RST_STUCK_MESSAGE_TIME = 16'd2000;
    localparam logic [CFG_W-1:0] RST_ON_DEMAND_CEILING  = 16'd30000;

    // input item
    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] boot_at_ms;
        logic [2:0]        boot_keys;
        logic              up_held;
        logic              any_key;
    } req_item_t;

    // result item
    typedef struct packed {
        logic [2:0]        stage;
        logic [2:0]        redraw;
        logic [SLOT_W-1:0] pattern_slot;
        logic              reset_taken;
    } rsp_item_t;

    // configuration registers
    typedef struct packed {
        logic [CFG_W-1:0] self_test_time;
        logic [CFG_W-1:0] pattern_period;
        logic [CFG_W-1:0] logo_time;
        logic [CFG_W-1:0] reset_hold_time;
        logic [CFG_W-1:0] stuck_deadline;
        logic [CFG_W-1:0] reset_message_time;
        logic [CFG_W-1:0] stuck_message_time;
        logic [CFG_W-1:0] on_demand_ceiling;
    } cfg_t;

    // divider handshake
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // remainder of an 8-bit slot by the pattern count, restoring bit steps
    function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_W-1:0] x,
                                                   input logic [SLOT_W-1:0] cnt);
        logic [SLOT_W:0] r;
        r = '0;
        if (cnt == '0)
        begin
            return '0;
        end
        for (int i = SLOT_W - 1; i >= 0; i--)
        begin
            r = {r[SLOT_W-1:0], x[i]};
            if (r >= {1'b0, cnt})
            begin
                r = r - {1'b0, cnt};
            end
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

FILE: design/bsrg_cfg.sv
// configuration register file behind an apb-style port
module bsrg_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsrg_pkg::PADDR_W-1:0]   paddr,
    input  logic [bsrg_pkg::PDATA_W-1:0]   pwdata,
    output logic [bsrg_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output bsrg_pkg::cfg_t                 cfg
);

    bsrg_pkg::cfg_t                   cfg_reg;
    bsrg_pkg::cfg_t                   cfg_next;
    logic                             wr_en;
    logic [bsrg_pkg::CFG_IDX_W-1:0]   idx;
    logic [bsrg_pkg::CFG_W-1:0]       wval;
    logic [bsrg_pkg::CFG_W-1:0]       rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[bsrg_pkg::PADDR_W-1:2];
    assign wval   = pwdata[bsrg_pkg::CFG_W-1:0];
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                bsrg_pkg::REG_SELF_TEST_TIME:     cfg_next.self_test_time     = wval;
                bsrg_pkg::REG_PATTERN_PERIOD:     cfg_next.pattern_period     = wval;
                bsrg_pkg::REG_LOGO_TIME:          cfg_next.logo_time          = wval;
                bsrg_pkg::REG_RESET_HOLD_TIME:    cfg_next.reset_hold_time    = wval;
                bsrg_pkg::REG_STUCK_DEADLINE:     cfg_next.stuck_deadline     = wval;
                bsrg_pkg::REG_RESET_MESSAGE_TIME: cfg_next.reset_message_time = wval;
                bsrg_pkg::REG_STUCK_MESSAGE_TIME: cfg_next.stuck_message_time = wval;
                bsrg_pkg::REG_ON_DEMAND_CEILING:  cfg_next.on_demand_ceiling  = wval;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            bsrg_pkg::REG_SELF_TEST_TIME:     rval = cfg_reg.self_test_time;
            bsrg_pkg::REG_PATTERN_PERIOD:     rval = cfg_reg.pattern_period;
            bsrg_pkg::REG_LOGO_TIME:          rval = cfg_reg.logo_time;
            bsrg_pkg::REG_RESET_HOLD_TIME:    rval = cfg_reg.reset_hold_time;
            bsrg_pkg::REG_STUCK_DEADLINE:     rval = cfg_reg.stuck_deadline;
            bsrg_pkg::REG_RESET_MESSAGE_TIME: rval = cfg_reg.reset_message_time;
            bsrg_pkg::REG_STUCK_MESSAGE_TIME: rval = cfg_reg.stuck_message_time;
            bsrg_pkg::REG_ON_DEMAND_CEILING:  rval = cfg_reg.on_demand_ceiling;
            default:                          rval = '0;
        endcase
    end

    assign prdata = {{(bsrg_pkg::PDATA_W - bsrg_pkg::CFG_W){1'b0}}, rval};

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.self_test_time     <= bsrg_pkg::RST_SELF_TEST_TIME;
            cfg_reg.pattern_period     <= bsrg_pkg::RST_PATTERN_PERIOD;
            cfg_reg.logo_time          <= bsrg_pkg::RST_LOGO_TIME;
            cfg_reg.reset_hold_time    <= bsrg_pkg::RST_RESET_HOLD_TIME;
            cfg_reg.stuck_deadline     <= bsrg_pkg::RST_STUCK_DEADLINE;
            cfg_reg.reset_message_time <= bsrg_pkg::RST_RESET_MESSAGE_TIME;
            cfg_reg.stuck_message_time <= bsrg_pkg::RST_STUCK_MESSAGE_TIME;
            cfg_reg.on_demand_ceiling  <= bsrg_pkg::RST_ON_DEMAND_CEILING;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/bsrg_div.sv
// bit-serial restoring divider, keeps the low slot bits of the quotient
module bsrg_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bsrg_pkg::TIME_W-1:0]   dividend,
    input  logic [bsrg_pkg::CFG_W-1:0]    divisor,
    output bsrg_pkg::div_status_t         status,
    output logic [bsrg_pkg::SLOT_W-1:0]   quot
);

    localparam int unsigned CNT_W = $clog2(bsrg_pkg::TIME_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bsrg_pkg::TIME_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [bsrg_pkg::TIME_W-1:0]   num_reg, num_next;
    logic [bsrg_pkg::CFG_W-1:0]    den_reg, den_next;
    logic [bsrg_pkg::CFG_W-1:0]    rem_reg, rem_next;
    logic [bsrg_pkg::SLOT_W-1:0]   quot_reg, quot_next;
    logic [bsrg_pkg::CFG_W:0]      trial;
    logic [bsrg_pkg::CFG_W:0]      diff;
    logic                          ge;

    // one quotient bit per cycle
    assign trial = {rem_reg, num_reg[bsrg_pkg::TIME_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[bsrg_pkg::CFG_W-1:0] : trial[bsrg_pkg::CFG_W-1:0];
            quot_next = {quot_reg[bsrg_pkg::SLOT_W-2:0], ge};
            num_next  = {num_reg[bsrg_pkg::TIME_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = quot_reg;

endmodule

FILE: design/boot_splash_reset_gesture_sequencer_top.sv
// top level of the boot splash sequencer with factory-reset gesture
//
//   channel  direction  handshake                   payload
//   req      in         req_valid / req_stall       req_item (bsrg_pkg::req_item_t)
//   rsp      out        rsp_valid / rsp_stall       rsp_item (bsrg_pkg::rsp_item_t)
//   cfg      in         psel penable pwrite pready  paddr pwdata prdata
//
// a tick during self-test first runs the 32-step serial divider that finds the pattern
// slot, then the sequencer finishes it; every other item goes straight to the finish state.
// req_stall stays high from acceptance until the result is loaded.
// a result stalled on rsp holds its register; the next item is accepted meanwhile
// and waits for the register before it finishes.
// rst_n clears the stage, flags and control registers to their power-on values.
module boot_splash_reset_gesture_sequencer_top
#(
    parameter int unsigned PATTERN_COUNT = bsrg_pkg::PATTERN_COUNT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bsrg_pkg::req_item_t           req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output bsrg_pkg::rsp_item_t           rsp_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsrg_pkg::PADDR_W-1:0]  paddr,
    input  logic [bsrg_pkg::PDATA_W-1:0]  pwdata,
    output logic [bsrg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam logic [bsrg_pkg::SLOT_W-1:0] PAT_CNT = bsrg_pkg::SLOT_W'(PATTERN_COUNT);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    bsrg_pkg::cfg_t                 cfg;
    bsrg_pkg::div_status_t          div_st;
    logic [bsrg_pkg::SLOT_W-1:0]    quot;
    logic                           div_start;
    logic [bsrg_pkg::TIME_W-1:0]    div_num;
    logic [bsrg_pkg::CFG_W-1:0]     period;

    logic [1:0]                     fsm_reg, fsm_next;
    bsrg_pkg::req_item_t            item_reg;
    logic                           accept;
    logic                           commit;

    logic [2:0]                     stage_reg, stage_next;
    logic [bsrg_pkg::TIME_W-1:0]    boot_time_reg, boot_time_next;
    logic [bsrg_pkg::TIME_W-1:0]    stage_start_reg, stage_start_next;
    logic [bsrg_pkg::SLOT_W-1:0]    shown_reg, shown_next;
    logic                           on_demand_reg, on_demand_next;
    logic                           exit_armed_reg, exit_armed_next;
    logic                           cand_reg, cand_next;
    logic                           pend_reg, pend_next;
    logic [2:0]                     redraw;
    logic                           taken;

    logic                           rsp_valid_reg, rsp_valid_next;
    bsrg_pkg::rsp_item_t            rsp_item_reg;

    logic [bsrg_pkg::TIME_W-1:0]    held;
    logic [bsrg_pkg::TIME_W-1:0]    since_boot;
    logic                           gesture_go;
    logic                           od_exit;

    bsrg_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage time divided by the pattern period, zero period counts as one
    assign period    = (cfg.pattern_period == '0) ? bsrg_pkg::CFG_W'(1) : cfg.pattern_period;
    assign div_num   = req_item.now_ms - stage_start_reg;
    assign accept    = req_valid && !req_stall;
    assign div_start = accept && (req_item.action == bsrg_pkg::ACT_TICK)
                       && (stage_reg == bsrg_pkg::STAGE_SELFTEST);

    bsrg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (period),
        .status   (div_st),
        .quot     (quot)
    );

    // sequencer
    assign req_stall = (fsm_reg != S_IDLE);
    assign commit    = (fsm_reg == S_FIN) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fsm_next = div_start ? S_DIV : S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    fsm_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (commit)
                begin
                    fsm_next = S_IDLE;
                end
            end
            default: fsm_next = S_IDLE;
        endcase
    end

    // time differences and gesture checks
    assign held       = item_reg.now_ms - stage_start_reg;
    assign since_boot = item_reg.now_ms - boot_time_reg;
    assign gesture_go = cand_reg && item_reg.up_held
                        && (since_boot >= {16'd0, cfg.reset_hold_time});
    assign od_exit    = ((exit_armed_reg || !item_reg.any_key) && item_reg.any_key)
                        || (held >= {16'd0, cfg.on_demand_ceiling});

    // step update
    always_comb
    begin
        stage_next       = stage_reg;
        boot_time_next   = boot_time_reg;
        stage_start_next = stage_start_reg;
        shown_next       = shown_reg;
        on_demand_next   = on_demand_reg;
        exit_armed_next  = exit_armed_reg;
        cand_next        = cand_reg;
        pend_next        = pend_reg;
        redraw           = bsrg_pkg::REDRAW_NONE;
        taken            = 1'b0;
        unique case (item_reg.action)
            bsrg_pkg::ACT_TICK:
            begin
                unique case (stage_reg)
                    bsrg_pkg::STAGE_SELFTEST:
                    begin
                        if (on_demand_reg && !item_reg.any_key)
                        begin
                            exit_armed_next = 1'b1;
                        end
                        if (on_demand_reg && od_exit)
                        begin
                            stage_next       = bsrg_pkg::STAGE_DONE;
                            stage_start_next = item_reg.now_ms;
                        end
                        else
                        begin
                            if (!on_demand_reg && (held >= {16'd0, cfg.self_test_time}))
                            begin
                                stage_next       = bsrg_pkg::STAGE_LOGO;
                                stage_start_next = item_reg.now_ms;
                                redraw           = bsrg_pkg::REDRAW_LOGO;
                            end
                            else if (quot != shown_reg)
                            begin
                                shown_next = bsrg_pkg::slot_mod(quot, PAT_CNT);
                                redraw     = bsrg_pkg::REDRAW_PATTERN;
                            end
                            // gesture check
                            if (cand_reg && !item_reg.up_held)
                            begin
                                cand_next = 1'b0;
                            end
                            else if (gesture_go)
                            begin
                                stage_next       = bsrg_pkg::STAGE_RESET;
                                stage_start_next = item_reg.now_ms;
                                redraw           = bsrg_pkg::REDRAW_RESET;
                            end
                        end
                    end
                    bsrg_pkg::STAGE_LOGO:
                    begin
                        if (cand_reg && !item_reg.up_held)
                        begin
                            cand_next = 1'b0;
                        end
                        if (gesture_go)
                        begin
                            stage_next       = bsrg_pkg::STAGE_RESET;
                            stage_start_next = item_reg.now_ms;
                            redraw           = bsrg_pkg::REDRAW_RESET;
                        end
                        else if (!(cand_reg && item_reg.up_held)
                                 && (held >= {16'd0, cfg.logo_time}))
                        begin
                            stage_next       = bsrg_pkg::STAGE_DONE;
                            stage_start_next = item_reg.now_ms;
                        end
                    end
                    bsrg_pkg::STAGE_RESET:
                    begin
                        if (item_reg.up_held)
                        begin
                            if (since_boot >= {16'd0, cfg.stuck_deadline})
                            begin
                                cand_next        = 1'b0;
                                stage_next       = bsrg_pkg::STAGE_STUCK;
                                stage_start_next = item_reg.now_ms;
                                redraw           = bsrg_pkg::REDRAW_STUCK;
                            end
                        end
                        else if (held >= {16'd0, cfg.reset_message_time})
                        begin
                            pend_next        = cand_reg;
                            cand_next        = 1'b0;
                            stage_next       = bsrg_pkg::STAGE_DONE;
                            stage_start_next = item_reg.now_ms;
                        end
                    end
                    bsrg_pkg::STAGE_STUCK:
                    begin
                        if (held >= {16'd0, cfg.stuck_message_time})
                        begin
                            stage_next       = bsrg_pkg::STAGE_DONE;
                            stage_start_next = item_reg.now_ms;
                        end
                    end
                    default:
                    begin
                        stage_next = stage_reg;
                    end
                endcase
            end
            bsrg_pkg::ACT_BOOT:
            begin
                boot_time_next   = item_reg.boot_at_ms;
                on_demand_next   = 1'b0;
                exit_armed_next  = 1'b0;
                pend_next        = 1'b0;
                cand_next        = (item_reg.boot_keys == 3'b001);
                shown_next       = '0;
                stage_next       = bsrg_pkg::STAGE_SELFTEST;
                stage_start_next = item_reg.now_ms;
                redraw           = bsrg_pkg::REDRAW_PATTERN;
            end
            bsrg_pkg::ACT_ON_DEMAND:
            begin
                boot_time_next   = item_reg.now_ms;
                on_demand_next   = 1'b1;
                exit_armed_next  = 1'b0;
                pend_next        = 1'b0;
                cand_next        = 1'b0;
                shown_next       = '0;
                stage_next       = bsrg_pkg::STAGE_SELFTEST;
                stage_start_next = item_reg.now_ms;
                redraw           = bsrg_pkg::REDRAW_PATTERN;
            end
            bsrg_pkg::ACT_TAKE:
            begin
                taken     = pend_reg;
                pend_next = 1'b0;
            end
            default:
            begin
                taken = 1'b0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= S_IDLE;
            rsp_valid_reg   <= 1'b0;
            stage_reg       <= bsrg_pkg::STAGE_IDLE;
            boot_time_reg   <= '0;
            stage_start_reg <= '0;
            shown_reg       <= bsrg_pkg::SLOT_NONE;
            on_demand_reg   <= 1'b0;
            exit_armed_reg  <= 1'b0;
            cand_reg        <= 1'b0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                stage_reg       <= stage_next;
                boot_time_reg   <= boot_time_next;
                stage_start_reg <= stage_start_next;
                shown_reg       <= shown_next;
                on_demand_reg   <= on_demand_next;
                exit_armed_reg  <= exit_armed_next;
                cand_reg        <= cand_next;
                pend_reg        <= pend_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req_item;
        end
        if (commit)
        begin
            rsp_item_reg.stage        <= stage_next;
            rsp_item_reg.redraw       <= redraw;
            rsp_item_reg.pattern_slot <= shown_next;
            rsp_item_reg.reset_taken  <= taken;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

FILE: design/bsrg_checker.sv
// port-level checks of the sequencer top and their bind
module bsrg_checker
#(
    parameter int unsigned PATTERN_COUNT = bsrg_pkg::PATTERN_COUNT_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_stall,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input bsrg_pkg::rsp_item_t  rsp_item
);

    localparam logic [bsrg_pkg::SLOT_W-1:0] PAT_CNT = bsrg_pkg::SLOT_W'(PATTERN_COUNT);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("stalled result changed");

    // the block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("item accepted without going busy");

    // a drawn pattern is always within the pattern set and shown in self-test
    a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.redraw == bsrg_pkg::REDRAW_PATTERN)
        |-> (rsp_item.pattern_slot < PAT_CNT)
            && (rsp_item.stage == bsrg_pkg::STAGE_SELFTEST))
        else $error("pattern redraw out of range or outside self-test");

    // the stuck screen is drawn only on entry to the stuck stage
    a_stuck_stage: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.redraw == bsrg_pkg::REDRAW_STUCK)
        |-> (rsp_item.stage == bsrg_pkg::STAGE_STUCK))
        else $error("stuck redraw outside stuck stage");

    // a taken reset comes from a take item, which draws nothing
    a_take_no_draw: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.reset_taken |-> (rsp_item.redraw == bsrg_pkg::REDRAW_NONE))
        else $error("reset taken together with a redraw");

endmodule

bind boot_splash_reset_gesture_sequencer_top bsrg_checker
#(
    .PATTERN_COUNT (PATTERN_COUNT)
)
u_bsrg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);
